/* hdl/assert_macros.svh */
// assertion helpers shared by the vector clock filter rtl
// plain text macros only, no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising clock edge out of reset
`define VCCF_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define VCCF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/vccf_pkg.sv */
// transaction types and codes for the vector clock causal filter
// no dependencies
`default_nettype none

package vccf_pkg;

   localparam int KIND_W  = 2;
   localparam int LEN_W   = 4;
   localparam int DEST_W  = 8;
   localparam int PORT_W  = 32;
   localparam int NODE_W  = 3;
   localparam int DROP_W  = 32;
   localparam int MAX_NODES = 8;

   // request kinds
   localparam logic REQ_LOCAL_SEND = 1'b0;
   localparam logic REQ_NETWORK    = 1'b1;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_SEND    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DELIVER = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DROP    = 2'd2;

   typedef struct packed {
      logic              req_type;
      logic              causal_enabled;
      logic [LEN_W-1:0]  peer_length;
      logic [DEST_W-1:0] dest_addr;
      logic [PORT_W-1:0] peer_stamp_0;
      logic [PORT_W-1:0] peer_stamp_1;
      logic [PORT_W-1:0] peer_stamp_2;
      logic [PORT_W-1:0] peer_stamp_3;
      logic [PORT_W-1:0] peer_stamp_4;
      logic [PORT_W-1:0] peer_stamp_5;
      logic [PORT_W-1:0] peer_stamp_6;
      logic [PORT_W-1:0] peer_stamp_7;
   } vccf_req_type;

   typedef struct packed {
      logic [KIND_W-1:0] result_kind;
      logic [DEST_W-1:0] out_dest;
      logic [LEN_W-1:0]  used_length;
      logic [DROP_W-1:0] dropped_total;
      logic [PORT_W-1:0] clock_0;
      logic [PORT_W-1:0] clock_1;
      logic [PORT_W-1:0] clock_2;
      logic [PORT_W-1:0] clock_3;
      logic [PORT_W-1:0] clock_4;
      logic [PORT_W-1:0] clock_5;
      logic [PORT_W-1:0] clock_6;
      logic [PORT_W-1:0] clock_7;
   } vccf_rsp_type;

endpackage

`default_nettype wire

/* hdl/vector_clock_causal_filter_core.sv */
// vector clock causal filter, top level
// uses vccf_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

// Each transaction passes an input register and then compare, merge and counter
// logic into the result register; one transaction is taken every cycle unless
// rsp_stall holds a full result register. The clock vector, used length and drop
// count are updated at the same edge that loads the result, so the next
// transaction always sees the fresh vector. A local send bumps this node's
// entry and returns the vector with the destination; a causal receive bumps the
// own entry, widens the used length and drops the message when the local vector
// strictly dominates the packet, otherwise it merges by entrywise maximum. The
// user must write node_index through csr_wr_en / csr_wr_data while no
// transaction is in flight; the block itself does not enforce this.
module vector_clock_causal_filter_core
   import vccf_pkg::*;
#(
   parameter int NODES      = 8,
   parameter int STAMP_BITS = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_wr_en,
   input  wire logic [NODE_W-1:0] csr_wr_data,
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire vccf_req_type      req_payload,
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      vccf_rsp_type      rsp_payload
);

   localparam int IDX_W = $clog2(NODES);

   logic [NODE_W-1:0]     node_index_ff;
   logic [STAMP_BITS-1:0] cv_ff [NODES];
   logic [STAMP_BITS-1:0] cv_in [NODES];
   logic [LEN_W-1:0]      len_ff, len_in;
   logic [DROP_W-1:0]     drop_ff, drop_in;

   logic                  req_valid_ff;
   vccf_req_type          req_ff;
   logic                  rsp_valid_ff;
   vccf_rsp_type          rsp_ff, rsp_in;

   logic                  out_load;
   logic [IDX_W-1:0]      own;
   logic [LEN_W-1:0]      cfg_len;
   logic [LEN_W-1:0]      plen;
   logic [STAMP_BITS-1:0] own_inc;
   logic [STAMP_BITS-1:0] cv_bump [NODES];
   logic [PORT_W-1:0]     peer_raw [MAX_NODES];
   logic [STAMP_BITS-1:0] peer [NODES];
   logic                  gt, lt;
   logic                  is_causal, is_drop;
   logic [KIND_W-1:0]     kind;
   logic [PORT_W-1:0]     clk_out [MAX_NODES];

   // handshake: input stage moves whenever the result register can load
   assign out_load  = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !out_load;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // own entry, clamped to the vector size
   assign own = (node_index_ff > NODE_W'(NODES - 1)) ? IDX_W'(NODES - 1)
                                                     : node_index_ff[IDX_W-1:0];
   assign cfg_len = ((csr_wr_data > NODE_W'(NODES - 1)) ? LEN_W'(NODES - 1)
                                                        : LEN_W'(csr_wr_data)) + LEN_W'(1);

   assign plen = (req_ff.peer_length > LEN_W'(NODES)) ? LEN_W'(NODES)
                                                      : req_ff.peer_length;

   assign peer_raw[0] = req_ff.peer_stamp_0;
   assign peer_raw[1] = req_ff.peer_stamp_1;
   assign peer_raw[2] = req_ff.peer_stamp_2;
   assign peer_raw[3] = req_ff.peer_stamp_3;
   assign peer_raw[4] = req_ff.peer_stamp_4;
   assign peer_raw[5] = req_ff.peer_stamp_5;
   assign peer_raw[6] = req_ff.peer_stamp_6;
   assign peer_raw[7] = req_ff.peer_stamp_7;

   assign own_inc   = cv_ff[own] + STAMP_BITS'(1);
   assign is_causal = (req_ff.req_type == REQ_NETWORK) && req_ff.causal_enabled;
   assign is_drop   = is_causal && gt && !lt;

   always_comb begin
      gt = 1'b0;
      lt = 1'b0;
      for (int i = 0; i < NODES; i++) begin
         cv_bump[i] = (IDX_W'(i) == own) ? own_inc : cv_ff[i];
         // packet entries past its length count as zero
         peer[i] = (LEN_W'(i) < plen) ? STAMP_BITS'(peer_raw[i]) : '0;
         if (cv_bump[i] > peer[i]) begin
            gt = 1'b1;
         end else if (cv_bump[i] < peer[i]) begin
            lt = 1'b1;
         end
      end
   end

   always_comb begin
      len_in  = len_ff;
      drop_in = drop_ff;
      kind    = KIND_DELIVER;
      for (int i = 0; i < NODES; i++) begin
         cv_in[i] = cv_ff[i];
      end
      if (req_ff.req_type == REQ_LOCAL_SEND) begin
         kind = KIND_SEND;
         for (int i = 0; i < NODES; i++) begin
            cv_in[i] = cv_bump[i];
         end
      end else if (is_causal) begin
         if (plen > len_ff) begin
            len_in = plen;
         end
         if (is_drop) begin
            kind    = KIND_DROP;
            drop_in = drop_ff + DROP_W'(1);
            for (int i = 0; i < NODES; i++) begin
               cv_in[i] = cv_bump[i];
            end
         end else begin
            for (int i = 0; i < NODES; i++) begin
               cv_in[i] = (peer[i] > cv_bump[i]) ? peer[i] : cv_bump[i];
            end
         end
      end
   end

   for (genvar g = 0; g < MAX_NODES; g++) begin : g_out
      if (g < NODES) begin : g_used
         assign clk_out[g] = PORT_W'(cv_in[g]);
      end else begin : g_unused
         assign clk_out[g] = '0;
      end
   end

   always_comb begin
      rsp_in.result_kind   = kind;
      rsp_in.out_dest      = (req_ff.req_type == REQ_LOCAL_SEND) ? req_ff.dest_addr : '0;
      rsp_in.used_length   = len_in;
      rsp_in.dropped_total = drop_in;
      rsp_in.clock_0       = clk_out[0];
      rsp_in.clock_1       = clk_out[1];
      rsp_in.clock_2       = clk_out[2];
      rsp_in.clock_3       = clk_out[3];
      rsp_in.clock_4       = clk_out[4];
      rsp_in.clock_5       = clk_out[5];
      rsp_in.clock_6       = clk_out[6];
      rsp_in.clock_7       = clk_out[7];
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         req_valid_ff <= req_valid;
      end
      if (req_valid && !req_stall) begin
         req_ff <= req_payload;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   // clock state
   always_ff @(posedge clock) begin
      if (reset) begin
         node_index_ff <= '0;
         len_ff        <= LEN_W'(1);
         drop_ff       <= '0;
         for (int i = 0; i < NODES; i++) begin
            cv_ff[i] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            node_index_ff <= csr_wr_data;
            // the used length only ever grows
            if (cfg_len > len_ff) begin
               len_ff <= cfg_len;
            end
         end else if (out_load) begin
            len_ff <= len_in;
         end
         if (out_load) begin
            drop_ff <= drop_in;
            for (int i = 0; i < NODES; i++) begin
               cv_ff[i] <= cv_in[i];
            end
         end
      end
   end

   `VCCF_ASSERT_NEXT(a_drop_count, clock, reset,
      out_load && (kind == KIND_DROP),
      drop_ff == $past(drop_ff) + DROP_W'(1), "drop counter did not advance")
   `VCCF_ASSERT_IMPL(a_len_covers_own, clock, reset, 1'b1,
      len_ff >= LEN_W'(own) + LEN_W'(1), "used length below own entry")
   `VCCF_ASSERT_IMPL(a_len_bound, clock, reset, 1'b1,
      len_ff <= LEN_W'(NODES), "used length beyond vector size")
   `VCCF_ASSERT_NEXT(a_plain_deliver_holds, clock, reset,
      out_load && (req_ff.req_type == REQ_NETWORK) && !req_ff.causal_enabled,
      (cv_ff[own] == $past(cv_ff[own])) && (drop_ff == $past(drop_ff)),
      "plain delivery changed the clock")

endmodule

`default_nettype wire
